FILE: hdl/can_signal_field_extractor_core_assert.svh
// ----------------------------------------------------------------------------
// CAN signal field extractor assertion macros
// Shared concurrent assertion forms; NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_FIELD_EXTRACTOR_CORE_ASSERT_SVH
`define CAN_SIGNAL_FIELD_EXTRACTOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication under synchronous reset.
`define CSFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csfe assertion failed");
// Next-cycle implication under synchronous reset.
`define CSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csfe assertion failed");
`else
`define CSFE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/csfe_pkg.sv
// ----------------------------------------------------------------------------
// csfe_pkg
// Types, constants and bit-reordering helpers for the signal extractor.
// ----------------------------------------------------------------------------
package csfe_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NUM_BYTES = DATA_W / BYTE_W;

  // Saturated signal length of a full 64-bit word.
  localparam logic [6:0] LEN_FULL = 7'd64;

  // Control that travels with every beat through the pipeline.
  typedef struct packed {
    logic       intel;  // Intel byte order
    logic       sgn;    // sign-extend the result
    logic       zero;   // empty payload or zero length
    logic [6:0] len;    // saturated length, 0..64
  } csfe_ctl_t;

  // Stage 1 output: source word and its right-shift amount.
  typedef struct packed {
    csfe_ctl_t         ctl;
    logic [DATA_W-1:0] word;
    logic [5:0]        shamt;
  } csfe_s1_t;

  // Stage 2 and stage 3 output: working word.
  typedef struct packed {
    csfe_ctl_t         ctl;
    logic [DATA_W-1:0] word;
  } csfe_word_t;

  // Reverse the bit order inside every byte. This maps DBC Motorola bit
  // numbering onto a linear index that rises by one per sawtooth step.
  function automatic logic [DATA_W-1:0] csfe_byte_rev(input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] r;
    for (int k = 0; k < NUM_BYTES; k++) begin
      for (int b = 0; b < BYTE_W; b++) begin
        r[k*BYTE_W + b] = d[k*BYTE_W + (BYTE_W - 1 - b)];
      end
    end
    return r;
  endfunction

  // Reverse the whole word.
  function automatic logic [DATA_W-1:0] csfe_word_rev(input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] r;
    for (int i = 0; i < DATA_W; i++) begin
      r[i] = d[DATA_W - 1 - i];
    end
    return r;
  endfunction

endpackage

FILE: hdl/csfe_prep.sv
// ----------------------------------------------------------------------------
// csfe_prep
// Stage 1: saturates count and length, masks unused bytes and picks the
// source word and shift amount for the selected byte order.
// ----------------------------------------------------------------------------
module csfe_prep #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     i_valid,
  output logic                     i_ready,
  input  logic [63:0]              i_frame_data,
  input  logic [3:0]               i_byte_count,
  input  logic [5:0]               i_start_bit,
  input  logic [6:0]               i_signal_length,
  input  logic                     i_little_endian,
  input  logic                     i_is_signed,
  output logic                     o_valid,
  input  logic                     o_ready,
  output csfe_pkg::csfe_s1_t       o_data
);
  import csfe_pkg::*;

  localparam logic [3:0] MaxCount = 4'(MAX_PAYLOAD_BYTES);

  logic              valid_r;
  logic              valid_nxt;
  csfe_s1_t          data_r;
  csfe_s1_t          data_nxt;
  logic [3:0]        cnt_sat;
  logic [6:0]        len_sat;
  logic [DATA_W-1:0] masked;

  assign i_ready = !valid_r || o_ready;

  // Saturate the descriptor and clear bytes beyond the byte count.
  always_comb begin
    cnt_sat = (i_byte_count > MaxCount) ? MaxCount : i_byte_count;
    len_sat = (i_signal_length > LEN_FULL) ? LEN_FULL : i_signal_length;
    for (int k = 0; k < NUM_BYTES; k++) begin
      masked[k*BYTE_W +: BYTE_W] = (4'(k) < cnt_sat) ? i_frame_data[k*BYTE_W +: BYTE_W]
                                                    : '0;
    end
  end

  // Motorola uses the byte-reversed word and the linear index of the MSB.
  always_comb begin
    data_nxt.ctl.intel = i_little_endian;
    data_nxt.ctl.sgn   = i_is_signed;
    data_nxt.ctl.zero  = (cnt_sat == 4'd0) || (len_sat == 7'd0);
    data_nxt.ctl.len   = len_sat;
    data_nxt.word      = i_little_endian ? masked : csfe_byte_rev(masked);
    data_nxt.shamt     = i_little_endian ? i_start_bit
                                         : {i_start_bit[5:3], ~i_start_bit[2:0]};
    valid_nxt          = i_ready ? i_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      data_r <= data_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule

FILE: hdl/csfe_shift.sv
// ----------------------------------------------------------------------------
// csfe_shift
// Stage 2: barrel shift that brings the first signal bit to bit 0.
// ----------------------------------------------------------------------------
module csfe_shift (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 i_valid,
  output logic                 i_ready,
  input  csfe_pkg::csfe_s1_t   i_data,
  output logic                 o_valid,
  input  logic                 o_ready,
  output csfe_pkg::csfe_word_t o_data
);
  import csfe_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  csfe_word_t data_r;
  csfe_word_t data_nxt;

  assign i_ready = !valid_r || o_ready;

  // Bits shifted in from above the payload read as zero.
  always_comb begin
    data_nxt.ctl  = i_data.ctl;
    data_nxt.word = i_data.word >> i_data.shamt;
    valid_nxt     = i_ready ? i_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      data_r <= data_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule

FILE: hdl/csfe_order.sv
// ----------------------------------------------------------------------------
// csfe_order
// Stage 3: for Motorola order, reverses the first length bits so that the
// first bit walked becomes the signal MSB.
// ----------------------------------------------------------------------------
module csfe_order (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 i_valid,
  output logic                 i_ready,
  input  csfe_pkg::csfe_word_t i_data,
  output logic                 o_valid,
  input  logic                 o_ready,
  output csfe_pkg::csfe_word_t o_data
);
  import csfe_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  csfe_word_t data_r;
  csfe_word_t data_nxt;
  logic [6:0] rsh;

  assign i_ready = !valid_r || o_ready;

  // Reversing the word and shifting down by 64 - len drops bits past len.
  always_comb begin
    rsh           = LEN_FULL - i_data.ctl.len;
    data_nxt.ctl  = i_data.ctl;
    data_nxt.word = i_data.ctl.intel ? i_data.word : (csfe_word_rev(i_data.word) >> rsh);
    valid_nxt     = i_ready ? i_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      data_r <= data_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule

FILE: hdl/csfe_sext.sv
// ----------------------------------------------------------------------------
// csfe_sext
// Stage 4: masks the value to its length, sign-extends and holds the
// result beat in the output register.
// ----------------------------------------------------------------------------
module csfe_sext (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 i_valid,
  output logic                 i_ready,
  input  csfe_pkg::csfe_word_t i_data,
  output logic                 o_valid,
  input  logic                 o_ready,
  output logic signed [63:0]   o_value
);
  import csfe_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;
  logic [DATA_W-1:0] len_mask;
  logic [5:0]        top_idx;
  logic              ext;

  assign i_ready = !valid_r || o_ready;

  // A full-length signal keeps every bit and is never extended.
  always_comb begin
    len_mask  = ~({DATA_W{1'b1}} << i_data.ctl.len);
    top_idx   = 6'(i_data.ctl.len - 7'd1);
    ext       = i_data.ctl.sgn && (i_data.ctl.len != LEN_FULL) && i_data.word[top_idx];
    value_nxt = (i_data.word & len_mask) | (ext ? ~len_mask : '0);
    if (i_data.ctl.zero) begin
      value_nxt = '0;
    end
    valid_nxt = i_ready ? i_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      value_r <= value_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_value = value_r;

endmodule

FILE: hdl/can_signal_field_extractor_core.sv
// ----------------------------------------------------------------------------
// can_signal_field_extractor_core
// Extracts one DBC signal (Intel or Motorola order, signed or unsigned)
// from a CAN payload of up to eight bytes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  frame, byte count, signal descriptor
//  out_     output     out_valid/out_stall raw_value
//
//  One beat per cycle while out_stall is low; each beat passes through
//  the four register stages in order: prepare, shift, reorder, extend.
//  Each stage refills as soon as its beat moves on, so bubbles collapse.
//  in_stall rises only when all four stages hold beats and out_stall is high.
//  Synchronous active-low reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
`include "can_signal_field_extractor_core_assert.svh"

module can_signal_field_extractor_core #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_frame_data,
  input  logic [3:0]         in_byte_count,
  input  logic [5:0]         in_start_bit,
  input  logic [6:0]         in_signal_length,
  input  logic               in_little_endian,
  input  logic               in_is_signed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_raw_value
);
  import csfe_pkg::*;

  logic       s1_valid;
  logic       s1_ready;
  csfe_s1_t   s1;
  logic       s2_valid;
  logic       s2_ready;
  csfe_word_t s2;
  logic       s3_valid;
  logic       s3_ready;
  csfe_word_t s3;
  logic       s4_ready;
  logic       in_ready;

  assign in_stall = !in_ready;

  // Stage 1: descriptor normalization and source selection.
  csfe_prep #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_prep (
    .clk            (clk),
    .rst_n          (rst_n),
    .i_valid        (in_valid),
    .i_ready        (in_ready),
    .i_frame_data   (in_frame_data),
    .i_byte_count   (in_byte_count),
    .i_start_bit    (in_start_bit),
    .i_signal_length(in_signal_length),
    .i_little_endian(in_little_endian),
    .i_is_signed    (in_is_signed),
    .o_valid        (s1_valid),
    .o_ready        (s1_ready),
    .o_data         (s1)
  );

  // Stage 2: alignment shift.
  csfe_shift u_shift (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_valid(s1_valid),
    .i_ready(s1_ready),
    .i_data (s1),
    .o_valid(s2_valid),
    .o_ready(s2_ready),
    .o_data (s2)
  );

  // Stage 3: Motorola bit reorder.
  csfe_order u_order (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_valid(s2_valid),
    .i_ready(s2_ready),
    .i_data (s2),
    .o_valid(s3_valid),
    .o_ready(s3_ready),
    .o_data (s3)
  );

  // Stage 4: length mask, sign extension and output register.
  csfe_sext u_sext (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_valid(s3_valid),
    .i_ready(s3_ready),
    .i_data (s3),
    .o_valid(out_valid),
    .o_ready(s4_ready),
    .o_value(out_raw_value)
  );

  assign s4_ready = !out_stall;

  // Input stalls only when every stage is full and the output is stalled.
  `CSFE_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, s1_valid && s2_valid && s3_valid && out_valid && out_stall)
  // A zero-length or empty-payload beat leaves the pipeline as zero.
  `CSFE_ASSERT_NEXT(a_zero_out, clk, rst_n, s3_valid && s3_ready && s3.ctl.zero, out_raw_value == 64'sd0)
  // Unsigned results have nothing set above the signal length.
  `CSFE_ASSERT_NEXT(a_unsigned_top, clk, rst_n, s3_valid && s3_ready && !s3.ctl.sgn, (out_raw_value >> $past(s3.ctl.len)) == 64'sd0)
  // A blocked middle stage keeps its beat.
  `CSFE_ASSERT_NEXT(a_s2_hold, clk, rst_n, s2_valid && !s2_ready, s2_valid && $stable(s2))

endmodule
